/* design/fim_pkg.sv */
// Shared types and constants for the frame interval running median block.
`default_nettype none

package fim_pkg;

  // Ring and timer geometry
  localparam int WINDOW    = 128;
  localparam int TIME_BITS = 48;
  localparam int IDX_W     = $clog2(WINDOW);

  // Scale register: ms per tick, 32 fractional bits
  localparam int SCALE_W     = 48;
  localparam int SCALE_LO_W  = SCALE_W / 2;
  localparam int SCALE_HI_W  = SCALE_W - SCALE_LO_W;

  // Result fields
  localparam int MED_W       = 32;
  localparam int CNT_OUT_W   = 7;
  localparam int FRAC_DROP   = 16;
  localparam int SAT_POS     = FRAC_DROP + MED_W;

  // Interval split for the shared multiplier
  localparam int DIFF_LO_W   = (TIME_BITS + 1) / 2;
  localparam int DIFF_HI_W   = TIME_BITS - DIFF_LO_W;
  localparam int PROD_W      = DIFF_LO_W + SCALE_LO_W;
  localparam int ACC_W       = TIME_BITS + SCALE_W;
  localparam int SHIFT_W     = $clog2(ACC_W);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64'h0000_0001_0000_0000);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [SCALE_W-1:0]   scale_t;
  typedef logic [MED_W-1:0]     med_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;

endpackage

`default_nettype wire

/* design/fim_if.sv */
// Valid/ready channel interfaces for timestamps in and median results out.
`default_nettype none

interface fim_ts_if import fim_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface fim_res_if import fim_pkg::*; ();
  logic     valid;
  logic     ready;
  med_t     median_interval;
  cnt_out_t interval_count;

  modport source (output valid, output median_interval, output interval_count, input ready);
  modport sink   (input valid, input median_interval, input interval_count, output ready);
endinterface

`default_nettype wire

/* design/fim_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module fim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/frame_interval_running_median_core.sv */
// Frame interval running median: ring of elapsed ticks, sorted interval list, scaler.
// Sequence: ring reads of the older neighbour, the slot and the newer neighbour; on removal,
//   a scan up the sorted entries (the count); on insertion, a set-up step and a scan down
//   that shifts entries (one more past the head); with a median to scale, its read, the
//   multiply-accumulate over the operand halves and saturation; then any wait for the
//   output register.
// Flow: one item at a time; the next item is taken the cycle after the result enters the
//   output register.
// Reset: origin unlatched, ring empty (valid bits cleared), sorted list empty,
//   tick_scale = 1.0, no result pending.
`default_nettype none

module frame_interval_running_median_core import fim_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  fim_ts_if.sink      sample,
  fim_res_if.source   result,
  input  wire logic   tick_scale_we,
  input  wire scale_t tick_scale_wdata
);

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;   // older neighbour arrives
  localparam logic [3:0] S_RD2  = 4'd2;   // old contents of the slot arrive
  localparam logic [3:0] S_RD3  = 4'd3;   // newer neighbour arrives, slot written
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_REM  = 4'd5;   // scan up, drop one interval, close gap
  localparam logic [3:0] S_INSA = 4'd6;
  localparam logic [3:0] S_INS  = 4'd7;   // scan down, open gap, place interval
  localparam logic [3:0] S_INSZ = 4'd8;
  localparam logic [3:0] S_SEL  = 4'd9;
  localparam logic [3:0] S_SELW = 4'd10;
  localparam logic [3:0] S_MUL  = 4'd11;
  localparam logic [3:0] S_ACC  = 4'd12;
  localparam logic [3:0] S_SAT  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  function automatic idx_t slot_inc(input idx_t s);
    return (s == idx_t'(WINDOW - 1)) ? '0 : idx_t'(s + 1'b1);
  endfunction

  function automatic time_t clamp_sub(input time_t a, input time_t b);
    return (a >= b) ? time_t'(a - b) : '0;
  endfunction

  // Control state
  logic [3:0]        state;
  time_t             origin;
  idx_t              ws;          // most recently written ring slot
  idx_t              cnt;         // intervals held in the sorted list
  logic [WINDOW-1:0] ring_vld;    // entry never written reads as empty
  logic              out_valid;
  scale_t            scale;

  // Working registers
  time_t                 elapsed;
  time_t                 older;
  time_t                 oldv;
  logic                  rem_ok;
  logic                  ins_ok;
  time_t                 rem_val;
  time_t                 ins_val;
  idx_t                  pj;
  logic                  found;
  time_t                 diff;
  logic [1:0]            mi;
  logic [PROD_W-1:0]     prod;
  logic [ACC_W-1:0]      acc;
  med_t                  med;
  med_t                  out_med;
  cnt_out_t              out_cnt;
  logic                  rv_q;

  // Memory ports
  idx_t  ring_raddr;
  logic  ring_we;
  time_t ring_q;
  time_t ring_eff;
  idx_t  srt_raddr;
  idx_t  srt_waddr;
  logic  srt_we;
  time_t srt_wdata;
  time_t srt_q;

  // Datapath helpers
  logic                   hit;
  logic                   last;
  logic                   gt;
  logic [DIFF_LO_W-1:0]   a_op;
  logic [SCALE_LO_W-1:0]  b_op;
  logic [SHIFT_W-1:0]     shamt;
  logic                   sat_hit;

  fim_ram #(.WIDTH(TIME_BITS), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ws),
    .wdata (elapsed),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  fim_ram #(.WIDTH(TIME_BITS), .DEPTH(WINDOW)) u_sorted (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_q)
  );

  assign sample.ready           = (state == S_IDLE) && !rst;
  assign result.valid           = out_valid;
  assign result.median_interval = out_med;
  assign result.interval_count  = out_cnt;

  assign ring_eff = rv_q ? ring_q : '0;
  assign hit      = (srt_q == rem_val);
  assign last     = (pj == idx_t'(cnt - 1'b1));
  assign gt       = (srt_q > ins_val);

  // Ring reads: older neighbour while idle, then the slot, then the newer neighbour
  assign ring_raddr = (state == S_RD2) ? slot_inc(ws) : ws;
  assign ring_we    = (state == S_RD3);

  // Multiplier operand selection: mi[1] picks the interval half, mi[0] the scale half
  assign a_op  = mi[1] ? DIFF_LO_W'(diff[TIME_BITS-1:DIFF_LO_W]) : diff[DIFF_LO_W-1:0];
  assign b_op  = mi[0] ? SCALE_LO_W'(scale[SCALE_W-1:SCALE_LO_W]) : scale[SCALE_LO_W-1:0];
  assign shamt = (mi[1] ? SHIFT_W'(DIFF_LO_W) : '0) + (mi[0] ? SHIFT_W'(SCALE_LO_W) : '0);
  assign sat_hit = |acc[ACC_W-1:SAT_POS];

  // Sorted list port control
  always_comb begin
    srt_raddr = '0;
    srt_waddr = '0;
    srt_we    = 1'b0;
    srt_wdata = srt_q;
    unique case (state)
      S_REM: begin
        srt_raddr = idx_t'(pj + 1'b1);
        srt_we    = found;
        srt_waddr = idx_t'(pj - 1'b1);
      end
      S_INSA: begin
        srt_raddr = idx_t'(cnt - 1'b1);
        srt_we    = (cnt == '0);
        srt_wdata = ins_val;
      end
      S_INS: begin
        srt_raddr = idx_t'(pj - 1'b1);
        srt_we    = 1'b1;
        srt_waddr = idx_t'(pj + 1'b1);
        srt_wdata = gt ? srt_q : ins_val;
      end
      S_INSZ: begin
        srt_we    = 1'b1;
        srt_wdata = ins_val;
      end
      S_SEL: begin
        srt_raddr = cnt >> 1;
      end
      default: begin
        srt_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rv_q <= ring_vld[ring_raddr];

    if (rst) begin
      state     <= S_IDLE;
      origin    <= '0;
      ws        <= idx_t'(WINDOW - 1);
      cnt       <= '0;
      ring_vld  <= '0;
      out_valid <= 1'b0;
      scale     <= SCALE_RESET;
    end else begin
      if (tick_scale_we) begin
        scale <= tick_scale_wdata;
      end
      // the output stage reloads the register itself when it hands over
      if (result.valid && result.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            // first nonzero timestamp becomes the origin; its entry reads as empty
            if (origin == '0) begin
              origin  <= sample.timestamp;
              elapsed <= '0;
            end else begin
              elapsed <= time_t'(sample.timestamp - origin);
            end
            ws    <= slot_inc(ws);
            state <= S_RD1;
          end
        end
        S_RD1: begin
          older <= ring_eff;
          state <= S_RD2;
        end
        S_RD2: begin
          oldv  <= ring_eff;
          state <= S_RD3;
        end
        S_RD3: begin
          // interval leaving the window: newer neighbour over the slot's old contents;
          // interval joining it: new elapsed value over the older neighbour
          rem_ok       <= (ring_eff != '0) && (oldv != '0);
          rem_val      <= clamp_sub(ring_eff, oldv);
          ins_ok       <= (elapsed != '0) && (older != '0);
          ins_val      <= clamp_sub(elapsed, older);
          ring_vld[ws] <= 1'b1;
          state        <= S_DEC;
        end
        S_DEC: begin
          pj    <= '0;
          found <= 1'b0;
          if (rem_ok && cnt != '0) begin
            state <= S_REM;
          end else if (ins_ok) begin
            state <= S_INSA;
          end else begin
            state <= S_SEL;
          end
        end
        S_REM: begin
          if (!found && hit) begin
            found <= 1'b1;
          end
          pj <= idx_t'(pj + 1'b1);
          if (last) begin
            if (found || hit) begin
              cnt <= idx_t'(cnt - 1'b1);
            end
            state <= ins_ok ? S_INSA : S_SEL;
          end
        end
        S_INSA: begin
          if (cnt == '0) begin
            cnt   <= idx_t'(1);
            state <= S_SEL;
          end else begin
            pj    <= idx_t'(cnt - 1'b1);
            state <= S_INS;
          end
        end
        S_INS: begin
          if (gt) begin
            if (pj == '0) begin
              state <= S_INSZ;
            end else begin
              pj <= idx_t'(pj - 1'b1);
            end
          end else begin
            cnt   <= idx_t'(cnt + 1'b1);
            state <= S_SEL;
          end
        end
        S_INSZ: begin
          cnt   <= idx_t'(cnt + 1'b1);
          state <= S_SEL;
        end
        S_SEL: begin
          if (cnt == '0) begin
            med   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_SELW;
          end
        end
        S_SELW: begin
          diff  <= srt_q;
          mi    <= '0;
          acc   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= a_op * b_op;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + (ACC_W'(prod) << shamt);
          mi  <= mi + 1'b1;
          state <= (mi == 2'd3) ? S_SAT : S_MUL;
        end
        S_SAT: begin
          med   <= sat_hit ? '1 : acc[SAT_POS-1:FRAC_DROP];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_med   <= med;
            out_cnt   <= CNT_OUT_W'(cnt);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The interval leaving the window must be present in the sorted list
  a_rem_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM && last) |-> (found || hit))
    else $error("interval to remove not found in sorted list");

  // An insertion never starts on a full list
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSA) |-> (cnt != idx_t'(WINDOW - 1)))
    else $error("insertion into full sorted list");

  // No intervals means a zero median
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.interval_count == '0) |-> (result.median_interval == '0))
    else $error("nonzero median with empty interval set");

  // An item taken with the sequencer back at rest starts the ring reads
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_RD1))
    else $error("accepted item did not start the ring reads");

endmodule

`default_nettype wire
